/* src/dual_budget_admission_control_macros.svh */
// Assertion macros for the dual budget admission control block.
// Clock i_clk and active-low reset i_rst_n are taken from the including module.
`ifndef DUAL_BUDGET_ADMISSION_CONTROL_MACROS_SVH
`define DUAL_BUDGET_ADMISSION_CONTROL_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define DBAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dbac: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define DBAC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dbac: same-cycle check failed");

`endif

/* src/dbac_pkg.sv */
// Package for the dual budget admission control block: action and refusal codes,
// register indexes and field widths. No dependencies.
package dbac_pkg;

    localparam int unsigned XFER_W = 32;
    localparam int unsigned EVAL_W = 24;
    localparam int unsigned ORD_W = 48;
    localparam int unsigned ROT_CNT_W = 32;
    localparam int unsigned SES_CNT_W = 48;
    localparam int unsigned IN_DATA_W = 104;
    localparam int unsigned OUT_DATA_W = 272;
    localparam int unsigned OUT_PAD_W = 5;

    typedef enum logic [1:0] {
        ACT_OPEN    = 2'd0,
        ACT_CHARGE  = 2'd1,
        ACT_DEFER   = 2'd2,
        ACT_PROMOTE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REF_NONE      = 2'd0,
        REF_NOT_LATER = 2'd1,
        REF_EXHAUSTED = 2'd2
    } t_refusal;

    localparam logic CFG_BUDGET_XFER = 1'b0;
    localparam logic CFG_BUDGET_EVAL = 1'b1;

endpackage

/* src/dual_budget_admission_control.sv */
// Dual budget admission control: top level, single module.
// Depends on dbac_pkg and dual_budget_admission_control_macros.svh.
//
// Usage:
//   Items arrive on the s_axis channel: tuser carries the action (open, charge,
//   defer, promote), tdata the rotation ordinal and the two cost parts. Each item
//   yields exactly one result beat on m_axis with the status and all counters.
//   Budgets per rotation are written on the cfg channel (index 0 transfer bytes,
//   index 1 evaluation units); they take effect at the next open. cfg is always
//   ready. The user must see that cfg is written only while the block is idle;
//   the block itself does not enforce this. An accepted beat is held in the input
//   register; its result goes to the result register when that item advances.
//   Throughput: one item per cycle while m_axis does not stall; the state compare
//   and subtract sits combinationally between the input and result registers.
//   When m_axis stalls, the result stays in the output register and one more
//   item waits in the input register; s_axis_tready then drops.
//   Reset (synchronous, active low) clears budgets, counters, the open rotation
//   and the valid flags of both pipeline registers.
`include "dual_budget_admission_control_macros.svh"

module dual_budget_admission_control (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [dbac_pkg::XFER_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [47:0] rotation_ordinal, [79:48] cost_transfer_bytes, [103:80] cost_eval_units
    input  logic [dbac_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] accepted, [2:1] refusal_code, [34:3] remaining_transfer,
    // [58:35] remaining_eval, [106:59] open_ordinal, [138:107] promoted_in_rotation,
    // [170:139] deferred_in_rotation, [218:171] promoted_in_session,
    // [266:219] deferred_in_session, [271:267] zero
    output logic [dbac_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // config
    logic [dbac_pkg::XFER_W-1:0]    r_budget_xfer;
    logic [dbac_pkg::EVAL_W-1:0]    r_budget_eval;

    // input register
    logic                           r_in_valid;
    dbac_pkg::t_action              r_in_action;
    logic [dbac_pkg::ORD_W-1:0]     r_in_ord;
    logic [dbac_pkg::XFER_W-1:0]    r_in_cost_xfer;
    logic [dbac_pkg::EVAL_W-1:0]    r_in_cost_eval;

    // block state
    logic [dbac_pkg::XFER_W-1:0]    r_left_xfer, n_left_xfer;
    logic [dbac_pkg::EVAL_W-1:0]    r_left_eval, n_left_eval;
    logic                           r_standing, n_standing;
    logic [dbac_pkg::ORD_W-1:0]     r_ord, n_ord;
    logic [dbac_pkg::ROT_CNT_W-1:0] r_rot_prom, n_rot_prom;
    logic [dbac_pkg::ROT_CNT_W-1:0] r_rot_def, n_rot_def;
    logic [dbac_pkg::SES_CNT_W-1:0] r_ses_prom, n_ses_prom;
    logic [dbac_pkg::SES_CNT_W-1:0] r_ses_def, n_ses_def;

    // result register
    logic                           r_out_valid;
    logic [dbac_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                           ok;
    dbac_pkg::t_refusal             code;
    logic                           advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget_xfer <= '0;
            r_budget_eval <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dbac_pkg::CFG_BUDGET_XFER: r_budget_xfer <= i_cfg_data;
                dbac_pkg::CFG_BUDGET_EVAL: r_budget_eval <= i_cfg_data[dbac_pkg::EVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action    <= dbac_pkg::t_action'(s_axis_tuser);
            r_in_ord       <= s_axis_tdata[47:0];
            r_in_cost_xfer <= s_axis_tdata[79:48];
            r_in_cost_eval <= s_axis_tdata[103:80];
        end
    end

    always_comb begin
        n_left_xfer = r_left_xfer;
        n_left_eval = r_left_eval;
        n_standing  = r_standing;
        n_ord       = r_ord;
        n_rot_prom  = r_rot_prom;
        n_rot_def   = r_rot_def;
        n_ses_prom  = r_ses_prom;
        n_ses_def   = r_ses_def;
        ok          = 1'b1;
        code        = dbac_pkg::REF_NONE;
        unique case (r_in_action)
            dbac_pkg::ACT_OPEN: begin
                if (r_standing && (r_in_ord <= r_ord)) begin
                    ok   = 1'b0;
                    code = dbac_pkg::REF_NOT_LATER;
                end else begin
                    n_left_xfer = r_budget_xfer;
                    n_left_eval = r_budget_eval;
                    n_standing  = 1'b1;
                    n_ord       = r_in_ord;
                    n_rot_prom  = '0;
                    n_rot_def   = '0;
                end
            end
            dbac_pkg::ACT_CHARGE: begin
                if ((r_in_cost_xfer <= r_left_xfer) && (r_in_cost_eval <= r_left_eval)) begin
                    n_left_xfer = r_left_xfer - r_in_cost_xfer;
                    n_left_eval = r_left_eval - r_in_cost_eval;
                end else begin
                    ok   = 1'b0;
                    code = dbac_pkg::REF_EXHAUSTED;
                end
            end
            dbac_pkg::ACT_DEFER: begin
                if (!(&r_rot_def)) begin
                    n_rot_def = r_rot_def + 1'b1;
                end
                if (!(&r_ses_def)) begin
                    n_ses_def = r_ses_def + 1'b1;
                end
            end
            dbac_pkg::ACT_PROMOTE: begin
                if (!(&r_rot_prom)) begin
                    n_rot_prom = r_rot_prom + 1'b1;
                end
                if (!(&r_ses_prom)) begin
                    n_ses_prom = r_ses_prom + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_xfer <= '0;
            r_left_eval <= '0;
            r_standing  <= 1'b0;
            r_ord       <= '0;
            r_rot_prom  <= '0;
            r_rot_def   <= '0;
            r_ses_prom  <= '0;
            r_ses_def   <= '0;
        end else if (advance) begin
            r_left_xfer <= n_left_xfer;
            r_left_eval <= n_left_eval;
            r_standing  <= n_standing;
            r_ord       <= n_ord;
            r_rot_prom  <= n_rot_prom;
            r_rot_def   <= n_rot_def;
            r_ses_prom  <= n_ses_prom;
            r_ses_def   <= n_ses_def;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {{dbac_pkg::OUT_PAD_W{1'b0}}, n_ses_def, n_ses_prom, n_rot_def,
                           n_rot_prom, n_ord, n_left_eval, n_left_xfer, code, ok};
        end
    end

    `DBAC_ASSERT_NEXT(a_open_stands,
        advance && (r_in_action == dbac_pkg::ACT_OPEN) && ok,
        r_standing && (r_rot_prom == '0) && (r_rot_def == '0))
    `DBAC_ASSERT_NEXT(a_refused_charge_keeps,
        advance && (r_in_action == dbac_pkg::ACT_CHARGE) && !ok,
        (r_left_xfer == $past(r_left_xfer)) && (r_left_eval == $past(r_left_eval)))
    `DBAC_ASSERT_NEXT(a_budget_only_refills_on_open,
        advance && (r_in_action != dbac_pkg::ACT_OPEN),
        (r_left_xfer <= $past(r_left_xfer)) && (r_left_eval <= $past(r_left_eval)))
    `DBAC_ASSERT_NEXT(a_session_monotonic,
        i_rst_n,
        (r_ses_prom >= $past(r_ses_prom)) && (r_ses_def >= $past(r_ses_def)))
    `DBAC_ASSERT_SAME(a_refusal_consistent,
        r_out_valid,
        r_out_data[0] == (r_out_data[2:1] == dbac_pkg::REF_NONE))

endmodule
